// File: rtl/core/sgr_pkg.sv
package sgr_pkg;

   localparam int DATA_W = 32;
   localparam int CFG_W = 10;
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = 2;

   typedef logic [DATA_W-1:0] sample_type;
   typedef logic [CFG_W-1:0] cfg_word_type;

   typedef enum logic {
      REG_GRAIN_COUNT = 1'b0,
      REG_ROTATION    = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      CFG_IDLE = 3'b001,
      CFG_DIV  = 3'b010,
      CFG_MUL  = 3'b100
   } cfg_state_type;

   typedef struct packed {
      logic busy;
      logic regrain;
   } cfg_stat_type;

endpackage

// File: rtl/core/spectral_grain_reverser_core.sv
// Reorders spectral frames of BLOCK_BINS+1 words, one word per transaction, and returns
// one word per transaction taken from the previous frame, so the output lags the input
// by exactly one frame and the first frame out is all zero. Bin 0 passes through; bins 1
// to BLOCK_BINS are rotated by the rotation register and then reversed grain by grain.
// The block takes one transaction per cycle while the output queue has room and no
// grain_count update is in progress: the frame store writes the current bin and reads
// the permuted bin of the other bank in the same cycle, and a three-entry output queue
// covers the registered read under backpressure. A write to grain_count holds the
// configuration channel through the divide and multiply states, and the input channel
// also through the regrain strobe and the walk that brings the grain counters back to
// the current bin. The rotation register takes effect at once.
module spectral_grain_reverser_core
   import sgr_pkg::*;
#(
   parameter int BLOCK_BINS = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  sample_type    req_tdata,   // [31:0] sample_in
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output sample_type    rsp_tdata,   // [31:0] sample_out
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  reg_index_type csr_addr,
   input  cfg_word_type  csr_wdata
);

   localparam int BW = $clog2(BLOCK_BINS + 1);
   localparam int AW = $clog2(2 * (BLOCK_BINS + 1));

   logic [BW-1:0]         grain_size, last_base;
   cfg_word_type          rotation;
   cfg_stat_type          cfg_stat;
   logic                  walking;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  frame_end, zero_out;
   sample_type            rd_data;
   logic [FIFO_PTR_W-1:0] fifo_count;
   logic                  accept;
   logic                  room;

   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  s1_zero_ff;

   sgr_cfg #(
      .BLOCK_BINS(BLOCK_BINS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .grain_size(grain_size),
      .last_base (last_base),
      .rotation  (rotation),
      .stat      (cfg_stat)
   );

   sgr_addr_gen #(
      .BLOCK_BINS(BLOCK_BINS)
   ) u_addr_gen (
      .clock     (clock),
      .reset     (reset),
      .grain_size(grain_size),
      .last_base (last_base),
      .rotation  (rotation),
      .regrain   (cfg_stat.regrain),
      .accept    (accept),
      .walking   (walking),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .frame_end (frame_end),
      .zero_out  (zero_out)
   );

   sgr_frame_store #(
      .BLOCK_BINS(BLOCK_BINS)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(wr_addr),
      .wr_data(req_tdata),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sgr_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(s1_zero_ff ? '0 : rd_data),
      .push_last(s1_last_ff),
      .pop      (rsp_tvalid && rsp_tready),
      .count    (fifo_count),
      .out_valid(rsp_tvalid),
      .out_data (rsp_tdata),
      .out_last (rsp_tlast)
   );

   assign room       = ((fifo_count + FIFO_PTR_W'(s1_valid_ff)) < FIFO_PTR_W'(FIFO_DEPTH));
   assign req_tready = room && !cfg_stat.busy && !cfg_stat.regrain && !walking;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= frame_end;
         s1_zero_ff <= zero_out;
      end
   end

endmodule

// File: rtl/core/sgr_cfg.sv
module sgr_cfg
   import sgr_pkg::*;
#(
   parameter int BLOCK_BINS = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  reg_index_type                        csr_addr,
   input  cfg_word_type                         csr_wdata,
   output logic [$clog2(BLOCK_BINS + 1)-1:0]    grain_size,
   output logic [$clog2(BLOCK_BINS + 1)-1:0]    last_base,
   output cfg_word_type                         rotation,
   output cfg_stat_type                         stat
);

   localparam int BW = $clog2(BLOCK_BINS + 1);
   localparam int RW = ((BW > CFG_W) ? BW : CFG_W) + 1;
   localparam int CW = $clog2(BW + 1);
   localparam int PW = BW + CFG_W;
   localparam logic [BW-1:0] BINS = BW'(BLOCK_BINS);

   cfg_state_type  state_ff, state_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [BW-1:0]  quot_ff, quot_in;
   logic [BW-1:0]  dvd_ff, dvd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   cfg_word_type   gc_ff, gc_in;
   logic [BW-1:0]  gs_ff, gs_in;
   logic [BW-1:0]  lb_ff, lb_in;
   cfg_word_type   rot_ff, rot_in;
   logic           regrain_ff, regrain_in;

   logic [RW-1:0]  rem_shift;
   logic           rem_ge;
   logic [PW-1:0]  product;
   logic           csr_write;
   int             rot_value;

   assign csr_ready = (state_ff == CFG_IDLE);
   assign csr_write = csr_valid && csr_ready;
   assign rem_shift = {rem_ff[RW-2:0], dvd_ff[BW-1]};
   assign rem_ge    = (rem_shift >= RW'(gc_ff));
   assign product   = PW'(quot_ff) * PW'(gc_ff - CFG_W'(1));
   assign rot_value = int'($signed(csr_wdata));

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      dvd_in     = dvd_ff;
      cnt_in     = cnt_ff;
      gc_in      = gc_ff;
      gs_in      = gs_ff;
      lb_in      = lb_ff;
      rot_in     = rot_ff;
      regrain_in = 1'b0;
      unique case (state_ff)
         CFG_IDLE: begin
            if (csr_write) begin
               unique case (csr_addr)
                  REG_GRAIN_COUNT: begin
                     if (csr_wdata != '0) begin
                        gc_in    = csr_wdata;
                        rem_in   = '0;
                        quot_in  = '0;
                        dvd_in   = BINS;
                        cnt_in   = CW'(BW);
                        state_in = CFG_DIV;
                     end
                  end
                  REG_ROTATION: begin
                     if (rot_value < BLOCK_BINS && rot_value > -BLOCK_BINS) begin
                        rot_in = csr_wdata;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CFG_DIV: begin
            rem_in  = rem_ge ? (rem_shift - RW'(gc_ff)) : rem_shift;
            quot_in = {quot_ff[BW-2:0], rem_ge};
            dvd_in  = {dvd_ff[BW-2:0], 1'b0};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = CFG_MUL;
            end
         end
         CFG_MUL: begin
            gs_in      = quot_ff;
            lb_in      = product[BW-1:0];
            regrain_in = 1'b1;
            state_in   = CFG_IDLE;
         end
         default: begin
            state_in = CFG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CFG_IDLE;
         gc_ff      <= CFG_W'(1);
         gs_ff      <= BINS;
         lb_ff      <= '0;
         rot_ff     <= '0;
         regrain_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         gc_ff      <= gc_in;
         gs_ff      <= gs_in;
         lb_ff      <= lb_in;
         rot_ff     <= rot_in;
         regrain_ff <= regrain_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvd_ff  <= dvd_in;
   end

   assign grain_size   = gs_ff;
   assign last_base    = lb_ff;
   assign rotation     = rot_ff;
   assign stat.busy    = (state_ff != CFG_IDLE);
   assign stat.regrain = regrain_ff;

endmodule

// File: rtl/core/sgr_addr_gen.sv
module sgr_addr_gen
   import sgr_pkg::*;
#(
   parameter int BLOCK_BINS = 512
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [$clog2(BLOCK_BINS + 1)-1:0]       grain_size,
   input  logic [$clog2(BLOCK_BINS + 1)-1:0]       last_base,
   input  cfg_word_type                            rotation,
   input  logic                                    regrain,
   input  logic                                    accept,
   output logic                                    walking,
   output logic [$clog2(2 * (BLOCK_BINS + 1))-1:0] wr_addr,
   output logic [$clog2(2 * (BLOCK_BINS + 1))-1:0] rd_addr,
   output logic                                    frame_end,
   output logic                                    zero_out
);

   localparam int BW = $clog2(BLOCK_BINS + 1);
   localparam int AW = $clog2(2 * (BLOCK_BINS + 1));
   localparam int SW = ((BW > CFG_W) ? BW : CFG_W) + 2;
   localparam logic [BW-1:0] BINS = BW'(BLOCK_BINS);
   localparam logic [AW-1:0] FRAME_LEN = AW'(BLOCK_BINS + 1);
   localparam logic [SW-1:0] BINS_S = SW'(BLOCK_BINS);

   logic [BW-1:0] pos_ff, pos_in;
   logic          bank_ff, bank_in;
   logic          primed_ff, primed_in;
   logic [BW-1:0] off_ff, off_in;
   logic [BW-1:0] base_ff, base_in;
   logic          walking_ff, walking_in;
   logic [BW-1:0] wc_ff, wc_in;

   logic [BW-1:0] adv_off, adv_base;
   logic          wrap;
   logic          in_last;
   logic [BW-1:0] pre;
   logic [SW-1:0] shifted, wrapped;
   logic [BW-1:0] src_bin, rd_bin, target;

   assign wrap     = ((off_ff + BW'(1)) == grain_size);
   assign adv_off  = wrap ? '0 : (off_ff + BW'(1));
   assign adv_base = wrap ? (base_ff + grain_size) : base_ff;
   assign in_last  = (grain_size == '0) || (base_ff >= last_base);
   assign pre      = in_last ? (last_base + (BINS - pos_ff))
                             : (base_ff + (grain_size - BW'(1) - off_ff));
   assign shifted  = {{(SW - BW){1'b0}}, pre} - {{(SW - CFG_W){rotation[CFG_W-1]}}, rotation};

   always_comb begin
      if (shifted[SW-1]) begin
         wrapped = shifted + BINS_S;
      end else if (shifted >= BINS_S) begin
         wrapped = shifted - BINS_S;
      end else begin
         wrapped = shifted;
      end
   end

   assign src_bin = wrapped[BW-1:0] + BW'(1);
   assign rd_bin  = (pos_ff == '0) ? '0 : src_bin;
   assign rd_addr = bank_ff ? AW'(rd_bin) : (AW'(rd_bin) + FRAME_LEN);
   assign wr_addr = bank_ff ? (AW'(pos_ff) + FRAME_LEN) : AW'(pos_ff);
   assign target  = (pos_ff == '0) ? '0 : (pos_ff - BW'(1));

   always_comb begin
      pos_in     = pos_ff;
      bank_in    = bank_ff;
      primed_in  = primed_ff;
      off_in     = off_ff;
      base_in    = base_ff;
      walking_in = walking_ff;
      wc_in      = wc_ff;
      if (regrain) begin
         off_in     = '0;
         base_in    = '0;
         wc_in      = '0;
         walking_in = 1'b1;
      end else if (walking_ff) begin
         if (wc_ff == target) begin
            walking_in = 1'b0;
         end else begin
            off_in  = adv_off;
            base_in = adv_base;
            wc_in   = wc_ff + BW'(1);
         end
      end else if (accept) begin
         if (pos_ff == BINS) begin
            pos_in    = '0;
            bank_in   = !bank_ff;
            primed_in = 1'b1;
            off_in    = '0;
            base_in   = '0;
         end else begin
            pos_in = pos_ff + BW'(1);
            if (pos_ff != '0) begin
               off_in  = adv_off;
               base_in = adv_base;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         bank_ff    <= 1'b0;
         primed_ff  <= 1'b0;
         off_ff     <= '0;
         base_ff    <= '0;
         walking_ff <= 1'b0;
         wc_ff      <= '0;
      end else begin
         pos_ff     <= pos_in;
         bank_ff    <= bank_in;
         primed_ff  <= primed_in;
         off_ff     <= off_in;
         base_ff    <= base_in;
         walking_ff <= walking_in;
         wc_ff      <= wc_in;
      end
   end

   assign walking   = walking_ff;
   assign frame_end = (pos_ff == BINS);
   assign zero_out  = !primed_ff;

endmodule

// File: rtl/core/sgr_frame_store.sv
module sgr_frame_store
   import sgr_pkg::*;
#(
   parameter int BLOCK_BINS = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [$clog2(2 * (BLOCK_BINS + 1))-1:0] wr_addr,
   input  sample_type                              wr_data,
   input  logic                                    rd_en,
   input  logic [$clog2(2 * (BLOCK_BINS + 1))-1:0] rd_addr,
   output sample_type                              rd_data
);

   localparam int DEPTH = 2 * (BLOCK_BINS + 1);

   sample_type mem [0:DEPTH-1];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sgr_out_fifo.sv
module sgr_out_fifo
   import sgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sample_type            push_data,
   input  logic                  push_last,
   input  logic                  pop,
   output logic [FIFO_PTR_W-1:0] count,
   output logic                  out_valid,
   output sample_type            out_data,
   output logic                  out_last
);

   localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);

   sample_type            data_ff [0:FIFO_DEPTH-1];
   logic                  last_ff [0:FIFO_DEPTH-1];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : (wr_ptr_ff + FIFO_PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : (rd_ptr_ff + FIFO_PTR_W'(1));
      end
      if (push && !pop) begin
         count_in = count_ff + FIFO_PTR_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
         last_ff[wr_ptr_ff] <= push_last;
      end
   end

   assign count     = count_ff;
   assign out_valid = (count_ff != '0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign out_last  = last_ff[rd_ptr_ff];

endmodule
